// ===== sv/cbor_hsp_pkg.sv =====
package cbor_hsp_pkg;

   // parse phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_ARG     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   // item type codes
   localparam logic [3:0] IT_NONE   = 4'd0;
   localparam logic [3:0] IT_UINT   = 4'd1;
   localparam logic [3:0] IT_NEGINT = 4'd2;
   localparam logic [3:0] IT_BYTES  = 4'd3;
   localparam logic [3:0] IT_TEXT   = 4'd4;
   localparam logic [3:0] IT_ARRAY  = 4'd5;
   localparam logic [3:0] IT_MAP    = 4'd6;
   localparam logic [3:0] IT_FALSE  = 4'd7;
   localparam logic [3:0] IT_TRUE   = 4'd8;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_OVERRUN   = 3'd2;
   localparam logic [2:0] ST_BAD_ARG   = 3'd3;
   localparam logic [2:0] ST_UNKNOWN   = 3'd4;

   // major types and additional-info codes
   localparam logic [2:0] MT_UINT   = 3'd0;
   localparam logic [2:0] MT_NEGINT = 3'd1;
   localparam logic [2:0] MT_BYTES  = 3'd2;
   localparam logic [2:0] MT_TEXT   = 3'd3;
   localparam logic [2:0] MT_ARRAY  = 3'd4;
   localparam logic [2:0] MT_MAP    = 3'd5;
   localparam logic [2:0] MT_TAG    = 3'd6;
   localparam logic [2:0] MT_SIMPLE = 3'd7;

   localparam logic [4:0] AI_ARG1  = 5'd24;
   localparam logic [4:0] AI_ARG2  = 5'd25;
   localparam logic [4:0] AI_ARG4  = 5'd26;
   localparam logic [4:0] AI_FALSE = 5'd20;
   localparam logic [4:0] AI_TRUE  = 5'd21;

   typedef struct packed {
      logic [3:0]         item_type;
      logic [2:0]         status;
      logic [31:0]        arg_value;
      logic signed [32:0] int_value;
      logic [31:0]        item_offset;
      logic [2:0]         header_bytes;
      logic               end_of_buffer;
   } result_type;

   typedef struct packed {
      logic one;
      logic two;
   } push_type;

endpackage

// ===== sv/cbor_hsp_core.sv =====
module cbor_hsp_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     start_of_buffer,
   input  logic [31:0]              buffer_length,
   output cbor_hsp_pkg::push_type   push,
   output cbor_hsp_pkg::result_type result0,
   output cbor_hsp_pkg::result_type result1
);
   import cbor_hsp_pkg::*;

   logic [31:0] byte_offset_ff, byte_offset_in;
   logic [1:0]  parse_phase_ff, parse_phase_in;
   logic [31:0] arg_acc_ff, arg_acc_in;
   logic [2:0]  arg_left_ff, arg_left_in;
   logic [31:0] payload_left_ff, payload_left_in;
   logic [2:0]  major_type_ff, major_type_in;
   logic [31:0] header_start_ff, header_start_in;
   logic        stopped_ff, stopped_in;

   function automatic result_type end_word(input logic [31:0] off);
      result_type r;
      r               = '0;
      r.item_type     = IT_NONE;
      r.status        = ST_OK;
      r.item_offset   = off;
      r.end_of_buffer = 1'b1;
      return r;
   endfunction

   function automatic result_type error_word(input logic [2:0] st, input logic [31:0] off);
      result_type r;
      r             = '0;
      r.item_type   = IT_NONE;
      r.status      = st;
      r.item_offset = off;
      return r;
   endfunction

   // decode one byte against the parser state
   always_comb begin
      logic [4:0]  ai;
      logic [2:0]  hl;
      logic        fin_en;
      logic        is_str;
      logic [3:0]  itype;
      logic [31:0] v;
      ai     = data_byte[4:0];
      hl     = 3'd1;
      fin_en = 1'b0;
      is_str = 1'b0;
      itype  = IT_NONE;
      v      = '0;

      byte_offset_in  = byte_offset_ff;
      parse_phase_in  = parse_phase_ff;
      arg_acc_in      = arg_acc_ff;
      arg_left_in     = arg_left_ff;
      payload_left_in = payload_left_ff;
      major_type_in   = major_type_ff;
      header_start_in = header_start_ff;
      stopped_in      = stopped_ff;
      push            = '0;
      result0         = '0;
      result1         = '0;

      if (accept) begin
         // a start flag clears the state before the byte is looked at
         if (start_of_buffer) begin
            byte_offset_in  = '0;
            parse_phase_in  = PH_HEADER;
            arg_acc_in      = '0;
            arg_left_in     = '0;
            payload_left_in = '0;
            major_type_in   = '0;
            header_start_in = '0;
            stopped_in      = 1'b0;
         end

         if (stopped_in) begin
            // drop the byte
         end else if (byte_offset_in >= buffer_length) begin
            result0        = end_word(byte_offset_in);
            push.one       = 1'b1;
            stopped_in     = 1'b1;
            parse_phase_in = PH_HEADER;
         end else begin
            case (parse_phase_in)
               PH_ARG: begin
                  arg_acc_in     = {arg_acc_in[23:0], data_byte};
                  byte_offset_in = byte_offset_in + 32'd1;
                  arg_left_in    = arg_left_in - 3'd1;
                  fin_en         = (arg_left_in == 3'd0);
               end
               PH_PAYLOAD: begin
                  byte_offset_in  = byte_offset_in + 32'd1;
                  payload_left_in = payload_left_in - 32'd1;
                  if (payload_left_in == 32'd0) begin
                     parse_phase_in = PH_HEADER;
                     if (byte_offset_in == buffer_length) begin
                        result0    = end_word(byte_offset_in);
                        push.one   = 1'b1;
                        stopped_in = 1'b1;
                     end
                  end
               end
               default: begin
                  header_start_in = byte_offset_in;
                  major_type_in   = data_byte[7:5];
                  case (ai)
                     AI_ARG1: hl = 3'd2;
                     AI_ARG2: hl = 3'd3;
                     AI_ARG4: hl = 3'd5;
                     default: hl = 3'd1;
                  endcase
                  if (ai > AI_ARG4) begin
                     result0        = error_word(ST_BAD_ARG, header_start_in);
                     push.one       = 1'b1;
                     stopped_in     = 1'b1;
                     parse_phase_in = PH_HEADER;
                  end else if (({1'b0, header_start_in} + {30'd0, hl}) >
                               {1'b0, buffer_length}) begin
                     result0        = error_word(ST_TRUNCATED, header_start_in);
                     push.one       = 1'b1;
                     stopped_in     = 1'b1;
                     parse_phase_in = PH_HEADER;
                  end else if (major_type_in == MT_TAG ||
                               (major_type_in == MT_SIMPLE && ai != AI_FALSE &&
                                ai != AI_TRUE)) begin
                     result0        = error_word(ST_UNKNOWN, header_start_in);
                     push.one       = 1'b1;
                     stopped_in     = 1'b1;
                     parse_phase_in = PH_HEADER;
                  end else begin
                     byte_offset_in = byte_offset_in + 32'd1;
                     if (hl == 3'd1) begin
                        arg_acc_in = {27'd0, ai};
                        fin_en     = 1'b1;
                     end else begin
                        arg_acc_in     = '0;
                        arg_left_in    = hl - 3'd1;
                        parse_phase_in = PH_ARG;
                     end
                  end
               end
            endcase

            // header complete: classify, check string length, emit
            if (fin_en) begin
               v = arg_acc_in;
               case (major_type_in)
                  MT_UINT:   itype = IT_UINT;
                  MT_NEGINT: itype = IT_NEGINT;
                  MT_BYTES:  itype = IT_BYTES;
                  MT_TEXT:   itype = IT_TEXT;
                  MT_ARRAY:  itype = IT_ARRAY;
                  MT_MAP:    itype = IT_MAP;
                  default:   itype = (v == {27'd0, AI_TRUE}) ? IT_TRUE : IT_FALSE;
               endcase
               is_str = (major_type_in == MT_BYTES) || (major_type_in == MT_TEXT);
               if (is_str && (({1'b0, byte_offset_in} + {1'b0, v}) >
                              {1'b0, buffer_length})) begin
                  result0        = error_word(ST_OVERRUN, header_start_in);
                  push.one       = 1'b1;
                  stopped_in     = 1'b1;
                  parse_phase_in = PH_HEADER;
               end else begin
                  result0.item_type    = itype;
                  result0.status       = ST_OK;
                  result0.arg_value    = v;
                  result0.item_offset  = header_start_in;
                  result0.header_bytes = byte_offset_in[2:0] - header_start_in[2:0];
                  if (major_type_in == MT_UINT) begin
                     result0.int_value = {1'b0, v};
                  end else if (major_type_in == MT_NEGINT) begin
                     result0.int_value = ~{1'b0, v};
                  end else begin
                     result0.int_value = '0;
                  end
                  push.one = 1'b1;
                  if (is_str && v != 32'd0) begin
                     parse_phase_in  = PH_PAYLOAD;
                     payload_left_in = v;
                  end else begin
                     parse_phase_in = PH_HEADER;
                     if (byte_offset_in == buffer_length) begin
                        result1    = end_word(byte_offset_in);
                        push.two   = 1'b1;
                        stopped_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   // hold the parser state; reset clears all of it
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff  <= '0;
         parse_phase_ff  <= PH_HEADER;
         arg_acc_ff      <= '0;
         arg_left_ff     <= '0;
         payload_left_ff <= '0;
         major_type_ff   <= '0;
         header_start_ff <= '0;
         stopped_ff      <= 1'b0;
      end else begin
         byte_offset_ff  <= byte_offset_in;
         parse_phase_ff  <= parse_phase_in;
         arg_acc_ff      <= arg_acc_in;
         arg_left_ff     <= arg_left_in;
         payload_left_ff <= payload_left_in;
         major_type_ff   <= major_type_in;
         header_start_ff <= header_start_in;
         stopped_ff      <= stopped_in;
      end
   end

   // a stopped parser stays silent until the next start flag
   assert property (@(posedge clock) disable iff (reset)
      (accept && stopped_ff && !start_of_buffer) |-> (!push.one && !push.two))
      else $error("stopped parser produced a word");

   // a second word is only ever the end marker
   assert property (@(posedge clock) disable iff (reset)
      push.two |-> (push.one && result1.end_of_buffer))
      else $error("second word is not an end marker");

   // an error or end marker stops the parser
   assert property (@(posedge clock) disable iff (reset)
      (push.one && (result0.status != ST_OK || result0.end_of_buffer)) |=> stopped_ff)
      else $error("parser not stopped after error or end");

endmodule

// ===== sv/cbor_hsp_queue.sv =====
module cbor_hsp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cbor_hsp_pkg::push_type   push,
   input  cbor_hsp_pkg::result_type result0,
   input  cbor_hsp_pkg::result_type result1,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_ready,
   output cbor_hsp_pkg::result_type out_word
);
   import cbor_hsp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   result_type    mem_ff [DEPTH];
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] wr_next;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= CW'(DEPTH - 2));
   assign wr_next   = wrap_inc(wr_ptr_ff);

   // advance pointers and occupancy
   always_comb begin
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      if (push.two) begin
         wr_ptr_in = wrap_inc(wr_next);
      end else if (push.one) begin
         wr_ptr_in = wr_next;
      end else begin
         wr_ptr_in = wr_ptr_ff;
      end
      count_in = count_ff + CW'(push.one) + CW'(push.two) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store pushed words
   always_ff @(posedge clock) begin
      if (push.one) begin
         mem_ff[wr_ptr_ff] <= result0;
      end
      if (push.two) begin
         mem_ff[wr_next] <= result1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (push.one && !room) |-> 1'b0)
      else $error("push into a queue without room");

   assert property (@(posedge clock) disable iff (reset)
      (push.one && !pop) |=> (count_ff != '0))
      else $error("pushed word not visible");

endmodule

// ===== sv/cbor_header_stream_parser_unit.sv =====
// With the queue empty, the first word of an accepted byte is on rsp in the cycle
// after; a second word from the same byte (end marker) follows behind it.
// Throughput: one byte per cycle; words wait in a QUEUE_DEPTH-entry result queue,
// and req_ready drops while more than QUEUE_DEPTH-2 words are held.
// Reset (synchronous, active high) clears the parser, the queue and the
// buffer length register; no clearing pass is needed.
module cbor_header_stream_parser_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_start_of_buffer,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_item_type,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_arg_value,
   output logic signed [32:0] rsp_int_value,
   output logic [31:0]        rsp_item_offset,
   output logic [2:0]         rsp_header_bytes,
   output logic               rsp_end_of_buffer,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_data
);
   import cbor_hsp_pkg::*;

   logic [31:0] buffer_length_ff, buffer_length_in;
   logic        accept;
   logic        room;
   push_type    push;
   result_type  result0, result1, out_word;

   assign csr_ready        = 1'b1;
   assign buffer_length_in = (csr_valid && csr_ready) ? csr_data : buffer_length_ff;

   // hold the buffer length register
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_length_ff <= '0;
      end else begin
         buffer_length_ff <= buffer_length_in;
      end
   end

   assign req_ready = room;
   assign accept    = req_valid && req_ready;

   cbor_hsp_core u_core (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .start_of_buffer (req_start_of_buffer),
      .buffer_length   (buffer_length_ff),
      .push            (push),
      .result0         (result0),
      .result1         (result1)
   );

   cbor_hsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .result0   (result0),
      .result1   (result1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_item_type     = out_word.item_type;
   assign rsp_status        = out_word.status;
   assign rsp_arg_value     = out_word.arg_value;
   assign rsp_int_value     = out_word.int_value;
   assign rsp_item_offset   = out_word.item_offset;
   assign rsp_header_bytes  = out_word.header_bytes;
   assign rsp_end_of_buffer = out_word.end_of_buffer;

endmodule
